@@ src/first_fit_block_allocator_top_assert.svh @@
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
// check an implication every clock, skipped in reset
`define FFBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// check that the consequent holds in the cycle after the antecedent
`define FFBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;
  localparam int MaxBlocks   = 256;
  localparam int HeaderBytes = 16;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);

  localparam logic       CMD_ALLOC = 1'b0;
  localparam logic       CMD_FREE  = 1'b1;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_SENTINEL = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic        command;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] payload_address;
    logic [2:0]  status;
    logic [31:0] used_bytes;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, reset scan
    logic rd;        // issue read of entry at scan index, or of shift source
    logic eval;      // evaluate registered read data
    logic tail;      // evaluate tail gap
    logic shift;     // move one entry (read already registered)
    logic insert;    // write new entry, bump count
    logic remove;    // drop count after shift-down
    logic clear;     // fresh pool
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // scan index reached count
    logic hit;        // evaluated entry matched
    logic fits;       // tail has room
    logic shift_done; // shift finished
    logic full;
    logic is_zero;
    logic is_sent;
  } dp_sts_t;
endpackage
`default_nettype wire

@@ src/ffba_datapath.sv @@
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, scan index, gap arithmetic and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_datapath
  import ffba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   req,
  input  wire logic [31:0] pool_base,
  input  wire logic [31:0] pool_length,
  input  wire dp_cmd_t    cmd,
  output dp_sts_t         sts,
  output logic [32:0]     new_addr,
  output logic [31:0]     used_bytes
);
  logic [63:0]     mem [MaxBlocks];
  logic [63:0]     rdata_r;
  logic            cmd_r;
  logic [31:0]     size_r, addr_r;
  logic [CntW-1:0] idx_r, idx_nxt, count_r, pos_r;
  logic [32:0]     prev_end_r;
  logic [31:0]     bytes_r;
  logic            down_r;
  logic            mv_r;
  logic [32:0]     need, pool_end, ent_addr, ent_end, space, tail_sp;
  logic [33:0]     pe_sum;
  logic [CntW-1:0] rd_idx;

  assign need = {1'b0, size_r} + 33'(HeaderBytes);
  assign pe_sum = {2'b0, pool_base} + {2'b0, pool_length};
  assign pool_end = pe_sum[32] ? 33'h0FFFFFFFF : pe_sum[32:0];
  assign ent_addr = {1'b0, rdata_r[31:0]};
  assign ent_end = ent_addr + 33'(HeaderBytes) + {1'b0, rdata_r[63:32]};
  assign space = (ent_addr > prev_end_r) ? ent_addr - prev_end_r : '0;
  assign tail_sp = (pool_end > prev_end_r) ? pool_end - prev_end_r : '0;

  // read address: scan index, or shift source
  always_comb begin
    rd_idx = idx_r;
    if (cmd.rd && mv_r) begin
      rd_idx = down_r ? idx_r + CntW'(1) : idx_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_idx[IdxW-1:0]];
    if (cmd.shift) begin
      mem[idx_r[IdxW-1:0]] <= rdata_r;
    end else if (cmd.insert) begin
      mem[pos_r[IdxW-1:0]] <= {size_r, prev_end_r[31:0]};
    end
  end

  assign sts.scan_done  = (idx_r == count_r);
  assign sts.hit = cmd_r ? (ent_addr + 33'(HeaderBytes) == {1'b0, addr_r})
                         : (space >= need);
  assign sts.fits       = (tail_sp >= need);
  assign sts.shift_done = down_r ? (idx_r + CntW'(1) >= count_r) : (idx_r == pos_r);
  assign sts.full       = (count_r == CntW'(MaxBlocks));
  assign sts.is_zero    = (addr_r == '0);
  assign sts.is_sent    = ({1'b0, addr_r} == {1'b0, pool_base} + 33'(HeaderBytes));
  assign new_addr = prev_end_r + 33'(HeaderBytes);
  assign used_bytes = bytes_r;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.eval && !sts.hit) idx_nxt = idx_r + CntW'(1);
    if (cmd.shift) idx_nxt = down_r ? idx_r + CntW'(1) : idx_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
      bytes_r <= '0;
      idx_r   <= '0;
      down_r  <= 1'b0;
      mv_r    <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.load) begin
        idx_r <= '0;
        down_r <= req.command;
        mv_r <= 1'b0;
        cmd_r <= req.command;
        size_r <= req.request_size;
        addr_r <= req.block_address;
        prev_end_r <= {1'b0, pool_base} + 33'(HeaderBytes);
      end
      if (cmd.eval && !sts.hit && !cmd_r) prev_end_r <= ent_end;
      if (cmd.eval && sts.hit) begin
        pos_r <= idx_r;
        mv_r <= 1'b1;
        if (!cmd_r) idx_r <= count_r;
        else bytes_r <= bytes_r - rdata_r[63:32] - 32'(HeaderBytes);
      end
      if (cmd.tail) begin
        pos_r <= count_r;
        idx_r <= count_r;
        mv_r <= 1'b1;
      end
      if (cmd.insert) begin
        count_r <= count_r + CntW'(1);
        bytes_r <= bytes_r + need[31:0];
      end
      if (cmd.remove) count_r <= count_r - CntW'(1);
    end
  end
endmodule
`default_nettype wire

@@ src/ffba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffba_ctrl
// Command sequencer: scan, shift, insert or remove, report.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    cfg_wr,
  input  wire logic    cmd_free,
  input  wire dp_sts_t sts,
  output logic         busy,
  output dp_cmd_t      cmd,
  output logic         done,
  output logic [2:0]   status,
  output logic         addr_ok
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RD, S_EVAL, S_SHRD, S_SHIFT, S_DONE
  } state_t;
  state_t     state_r, state_nxt;
  logic [2:0] status_r, status_nxt;
  logic       ok_r, ok_nxt;
  logic       done_r, done_nxt;

  assign busy = (state_r != S_IDLE);
  assign done = done_r;
  assign status = status_r;
  assign addr_ok = ok_r;

  always_comb begin
    state_nxt = state_r;
    status_nxt = status_r;
    ok_nxt = 1'b0;
    done_nxt = 1'b0;
    cmd = '0;
    cmd.clear = cfg_wr;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_RD;
        if (cmd_free) begin
          if (sts.is_zero) begin
            status_nxt = ST_ZERO; state_nxt = S_DONE;
          end else if (sts.is_sent) begin
            status_nxt = ST_SENTINEL; state_nxt = S_DONE;
          end
        end else if (sts.full) begin
          status_nxt = ST_FULL; state_nxt = S_DONE;
        end
      end
      S_RD: begin
        if (sts.scan_done) begin
          if (cmd_free) begin
            status_nxt = ST_UNKNOWN; state_nxt = S_DONE;
          end else if (sts.fits) begin
            cmd.tail = 1'b1; state_nxt = S_SHRD;
          end else begin
            status_nxt = ST_NO_SPACE; state_nxt = S_DONE;
          end
        end else begin
          cmd.rd = 1'b1; state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = sts.hit ? S_SHRD : S_RD;
      end
      S_SHRD: begin
        if (sts.shift_done) begin
          status_nxt = ST_OK;
          state_nxt = S_DONE;
          if (cmd_free) cmd.remove = 1'b1;
          else begin
            cmd.insert = 1'b1; ok_nxt = 1'b1;
          end
        end else begin
          cmd.rd = 1'b1; state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1; state_nxt = S_SHRD;
      end
      S_DONE: begin
        done_nxt = 1'b1; ok_nxt = ok_r; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
      ok_r <= 1'b0;
      status_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
      ok_r <= ok_nxt;
      status_r <= status_nxt;
    end
  end
endmodule
`default_nettype wire

@@ src/first_fit_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over an address-ordered block table.
// ----------------------------------------------------------------------------
// Use: raise start with in_item while busy is low; the request is taken at
// that edge. Exactly one result appears later on out_item for one cycle,
// flagged by out_valid; the receiver cannot stall and must take it.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 pool_base,
// 1 pool_length) and cfg_data. Writing either register empties the pool.
// Sequence: the scan reads (S_RD) and then evaluates (S_EVAL) each table
// entry in turn (one RAM read port), and a shift moves one entry per read
// (S_SHRD) and write (S_SHIFT). Requests rejected by the zero, sentinel or
// full checks skip the scan. One request is worked at a time.
// Reset: synchronous active-low rst_n empties the table and clears the
// byte count, pool registers and control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_block_allocator_top
  import ffba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [31:0] pool_base_r, pool_length_r;
  logic        cfg_wr, cmd_free_r, addr_ok;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [32:0] new_addr;
  logic [31:0] used;
  logic [2:0]  status;
  logic [31:0] addr_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      pool_length_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == 1'b0) pool_base_r <= cfg_data;
      else pool_length_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) cmd_free_r <= in_item.command;
    if (cmd.insert) addr_r <= new_addr[31:0];
  end

  ffba_ctrl u_ctrl (
    .clk, .rst_n, .start, .cfg_wr, .cmd_free(cmd_free_r), .sts,
    .busy, .cmd, .done(out_valid), .status, .addr_ok
  );

  ffba_datapath u_dp (
    .clk, .rst_n, .req(in_item), .pool_base(pool_base_r),
    .pool_length(pool_length_r), .cmd, .sts, .new_addr, .used_bytes(used)
  );

  assign out_item.payload_address = addr_ok ? addr_r : '0;
  assign out_item.status = status;
  assign out_item.used_bytes = used;

  `include "first_fit_block_allocator_top_assert.svh"
  `FFBA_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `FFBA_ASSERT_IMP(a_valid_idle, out_valid, !busy)
  `FFBA_ASSERT_IMP(a_addr_ok, out_valid && addr_ok, status == ST_OK)
endmodule
`default_nettype wire

@@ sim/tb_first_fit_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_top
// Self-checking bench for the first-fit block allocator.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and sent by a clocked driver
// with random gaps. A clocked monitor predicts each accepted request against
// a local copy of the block table and compares every result, field by field.
// Pool registers are rewritten between phases once the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_first_fit_block_allocator_top;
  import ffba_pkg::*;

  localparam int DrainCycles = 2 * MaxBlocks + 60;
  localparam int StallLimit  = 8000;

  typedef struct {
    in_item_t req;
    bit       pick_live;
  } pending_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pending_req_t pending_reqs[$];
  out_item_t    expected_results[$];
  logic [31:0]  blk_addr[$];
  logic [31:0]  blk_len[$];
  logic [31:0]  pool_base_q = '0;
  logic [31:0]  pool_len_q = '0;
  logic [31:0]  used_q = '0;
  logic         taken = 1'b0;
  int           gap_left = 0;
  bit           no_idle = 1'b0;
  int           err_count = 0;
  int           stall_cycles = 0;

  first_fit_block_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", field, want, got, $time);
    err_count++;
  endtask

  function automatic out_item_t allocate_or_free(input in_item_t r);
    out_item_t   res;
    logic [63:0] need, prev_end, pend, space, nxt;
    int          pos;
    bit          found;
    res = '0;
    if (r.command == CMD_ALLOC) begin
      need = {32'd0, r.request_size} + HeaderBytes;
      prev_end = {32'd0, pool_base_q} + HeaderBytes;
      pend = {32'd0, pool_base_q} + {32'd0, pool_len_q};
      if (pend > 64'hFFFF_FFFF) pend = 64'hFFFF_FFFF;
      found = 1'b0;
      pos = blk_addr.size();
      if (blk_addr.size() >= MaxBlocks) begin
        res.status = ST_FULL;
      end else begin
        for (int i = 0; i < blk_addr.size() && !found; i++) begin
          nxt = {32'd0, blk_addr[i]};
          space = (nxt > prev_end) ? nxt - prev_end : 64'd0;
          if (space >= need) begin
            found = 1'b1;
            pos = i;
          end else begin
            prev_end = nxt + HeaderBytes + {32'd0, blk_len[i]};
          end
        end
        space = (pend > prev_end) ? pend - prev_end : 64'd0;
        if (!found && space < need) begin
          res.status = ST_NO_SPACE;
        end else begin
          blk_addr.insert(pos, prev_end[31:0]);
          blk_len.insert(pos, r.request_size);
          used_q = used_q + need[31:0];
          res.payload_address = prev_end[31:0] + HeaderBytes;
          res.status = ST_OK;
        end
      end
    end else begin
      res.status = ST_UNKNOWN;
      if (r.block_address == 32'd0) begin
        res.status = ST_ZERO;
      end else if ({32'd0, r.block_address} == {32'd0, pool_base_q} + HeaderBytes) begin
        res.status = ST_SENTINEL;
      end else begin
        for (int i = 0; i < blk_addr.size(); i++) begin
          if (res.status == ST_UNKNOWN &&
              {32'd0, blk_addr[i]} + HeaderBytes == {32'd0, r.block_address}) begin
            used_q = used_q - blk_len[i] - HeaderBytes;
            blk_addr.delete(i);
            blk_len.delete(i);
            res.status = ST_OK;
          end
        end
      end
    end
    res.used_bytes = used_q;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, out_item.payload_address);
        end else begin
          want = expected_results.pop_front();
          if (want.payload_address !== out_item.payload_address)
            report_mismatch("payload_address", want.payload_address,
                            out_item.payload_address);
          if (want.status !== out_item.status)
            report_mismatch("status", {29'd0, want.status}, {29'd0, out_item.status});
          if (want.used_bytes !== out_item.used_bytes)
            report_mismatch("used_bytes", want.used_bytes, out_item.used_bytes);
        end
      end
      if (start && !busy) expected_results.push_back(allocate_or_free(in_item));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 1'd0) pool_base_q = cfg_data;
        else pool_len_q = cfg_data;
        blk_addr.delete();
        blk_len.delete();
        used_q = '0;
      end
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
    taken <= rst_n && start && !busy;
  end

  always @(negedge clk) begin
    pending_req_t p;
    in_item_t     r;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_reqs.size() > 0) begin
      p = pending_reqs.pop_front();
      r = p.req;
      if (p.pick_live && blk_addr.size() > 0)
        r.block_address = blk_addr[$urandom_range(0, blk_addr.size() - 1)] + HeaderBytes;
      in_item <= r;
      start <= 1'b1;
      gap_left <= no_idle ? 0 : $urandom_range(0, 11);
    end else begin
      start <= 1'b0;
    end
  end

  task automatic queue_req(input logic cmd, input logic [31:0] size,
                           input logic [31:0] addr, input bit live);
    pending_req_t p;
    p.req.command = cmd;
    p.req.request_size = size;
    p.req.block_address = addr;
    p.pick_live = live;
    pending_reqs.push_back(p);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_pool(input logic [31:0] base, input logic [31:0] len);
    for (int i = 0; i < 2; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= i[0:0];
      cfg_data <= (i == 0) ? base : len;
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [31:0] base, input logic [31:0] len,
                              input int count, input int alloc_pct, input int max_size);
    int roll;
    logic [31:0] size;
    wait_idle();
    write_pool(base, len);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        size = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, max_size);
        queue_req(CMD_ALLOC, size, $urandom(), 1'b0);
      end else if (roll < 94) begin
        queue_req(CMD_FREE, $urandom(), $urandom(), 1'b1);
      end else if (roll < 96) begin
        queue_req(CMD_FREE, $urandom(), base + HeaderBytes, 1'b0);
      end else if (roll < 97) begin
        queue_req(CMD_FREE, $urandom(), 32'd0, 1'b0);
      end else begin
        queue_req(CMD_FREE, $urandom(), $urandom(), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pool after reset
    queue_req(CMD_ALLOC, 32'd0, 32'd0, 1'b0);
    queue_req(CMD_FREE, 32'd0, 32'd0, 1'b0);
    queue_req(CMD_FREE, 32'd0, HeaderBytes, 1'b0);
    queue_req(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    wait_idle();

    // short pool: sentinel runs past the clamped end
    write_pool(32'hFFFF_FFF8, 32'hFFFF_FFFF);
    queue_req(CMD_ALLOC, 32'd0, 32'd0, 1'b0);
    wait_idle();

    // whole address space
    write_pool(32'd0, 32'hFFFF_FFFF);
    queue_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b0);
    queue_req(CMD_ALLOC, 32'hFFFF_FFDF, 32'd0, 1'b0);
    queue_req(CMD_ALLOC, 32'd0, 32'd0, 1'b0);
    queue_req(CMD_FREE, 32'd0, 32'd32, 1'b0);
    queue_req(CMD_FREE, 32'd0, 32'd33, 1'b0);
    queue_req(CMD_ALLOC, 32'd0, 32'd0, 1'b0);
    queue_req(CMD_ALLOC, 32'd4, 32'd0, 1'b0);
    wait_idle();

    write_pool(32'h0000_1000, 32'h0000_0100);
    queue_req(CMD_ALLOC, 32'd0, 32'd0, 1'b0);
    queue_req(CMD_ALLOC, 32'd100, 32'd0, 1'b0);
    queue_req(CMD_ALLOC, 32'd8, 32'd0, 1'b0);
    queue_req(CMD_FREE, 32'd0, 32'h0000_1030, 1'b0);
    queue_req(CMD_ALLOC, 32'd200, 32'd0, 1'b0);
    queue_req(CMD_ALLOC, 32'd60, 32'd0, 1'b0);
    queue_req(CMD_FREE, 32'd0, 32'h0000_1010, 1'b0);
    queue_req(CMD_FREE, 32'd0, 32'h0000_1020, 1'b0);
    queue_req(CMD_FREE, 32'd0, 32'd0, 1'b1);

    // table full
    random_phase(32'h0002_0000, 32'h0001_0000, 300, 100, 8);
    queue_req(CMD_FREE, 32'd0, 32'd0, 1'b1);
    queue_req(CMD_ALLOC, 32'd3, 32'd0, 1'b0);
    queue_req(CMD_ALLOC, 32'd3, 32'd0, 1'b0);

    random_phase($urandom(), $urandom_range(0, 4096), 200, 55, 300);
    random_phase(32'h8000_0000, 32'h0000_4000, 300, 60, 200);
    random_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 250, 55, 2000);
    random_phase($urandom(), $urandom(), 250, 55, 64);
    random_phase(32'h0000_0000, 32'h0000_0800, 300, 50, 48);
    random_phase($urandom(), 32'h0000_2000, 200, 65, 32);
    wait_idle();

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
